// ----- rtl/core/wts_pkg.sv -----
// ----------------------------------------------------------------------------
// wts_pkg: shared definitions for the waypoint time scaler
// Field widths, register indexes, reset values and the structs that pass
// between the sequencer, the divider and the top level.
// ----------------------------------------------------------------------------
package wts_pkg;

  // Joint fields carried by every input word, and the default joint count.
  localparam int FIELD_JOINTS     = 7;
  localparam int NUM_JOINTS_DEF   = 7;

  localparam int POS_W            = 20;   // Q4.16 signed radians
  localparam int SPEED_W          = 16;   // Q4.12 unsigned rad/s
  localparam int SPEED_FRAC       = 12;
  localparam int TIME_W           = 32;   // 1/65536 s
  localparam int DIVIDEND_W       = POS_W + SPEED_FRAC;

  localparam int IN_DATA_W        = ((FIELD_JOINTS * POS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W       = 2 * TIME_W;
  localparam int CFG_IDX_W        = 4;

  localparam logic [TIME_W-1:0]  TIME_MAX          = '1;
  localparam logic [SPEED_W-1:0] SPEED_RESET       = 16'd8192;
  localparam logic [SPEED_W-1:0] MIN_SEG_RESET     = 16'd6554;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_0 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_6 = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG     = 4'd7;

  typedef logic [FIELD_JOINTS-1:0][POS_W-1:0]   joints_t;
  typedef logic [FIELD_JOINTS-1:0][SPEED_W-1:0] speeds_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SPEED_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [TIME_W-1:0] elapsed_time;
    logic [TIME_W-1:0] segment_time;
    logic              saturated;
  } result_t;

endpackage

// ----- rtl/core/wts_div.sv -----
// ----------------------------------------------------------------------------
// wts_div: serial restoring divider
// Unsigned dividend by a 16-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wts_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wts_pkg::div_req_t req,
  output wts_pkg::div_rsp_t rsp
);

  localparam int DW = wts_pkg::DIVIDEND_W;
  localparam int SW = wts_pkg::SPEED_W;
  localparam int CW = $clog2(DW);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [SW-1:0] rem_r;
  logic [SW-1:0] dvs_r;
  logic [DW-1:0] quo_r;

  logic [SW:0]   trial_nxt;
  logic [SW+1:0] diff_nxt;
  logic          ge_nxt;

  // The partial remainder stays below the divisor, so one spare bit suffices.
  assign trial_nxt = {rem_r, quo_r[DW-1]};
  assign diff_nxt  = {1'b0, trial_nxt} - {2'b00, dvs_r};
  assign ge_nxt    = ~diff_nxt[SW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= ge_nxt ? diff_nxt[SW-1:0] : trial_nxt[SW-1:0];
        quo_r <= {quo_r[DW-2:0], ge_nxt};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  // A finished division must follow a cycle in which the divider was working.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider finished without having been busy");

endmodule

// ----- rtl/core/wts_seq.sv -----
// ----------------------------------------------------------------------------
// wts_seq: waypoint sequencer
// Walks the joints one at a time through the shared divider, keeps the
// largest joint time, clamps it and adds it to the running time.
// ----------------------------------------------------------------------------
module wts_seq #(
  parameter int NUM_JOINTS = wts_pkg::NUM_JOINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_start,
  input  wts_pkg::joints_t     in_joints,
  input  wts_pkg::speeds_t     speed,
  input  logic [wts_pkg::SPEED_W-1:0] min_seg,
  output logic                 res_valid,
  input  logic                 res_ready,
  output wts_pkg::result_t     res
);

  localparam int USED = (NUM_JOINTS > wts_pkg::FIELD_JOINTS) ? wts_pkg::FIELD_JOINTS
                                                             : NUM_JOINTS;
  localparam int JW   = (USED > 1) ? $clog2(USED) : 1;
  localparam int PW   = wts_pkg::POS_W;
  localparam int TW   = wts_pkg::TIME_W;
  localparam int SW   = wts_pkg::SPEED_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_WAIT,
    S_SUM,
    S_HOLD
  } state_t;

  state_t            state_r;
  logic [JW-1:0]     jcnt_r;
  logic [PW-1:0]     pos_r  [USED];
  logic [PW-1:0]     prev_r [USED];
  logic [TW-1:0]     run_r;
  logic [TW-1:0]     seg_r;
  logic              sat_r;
  wts_pkg::result_t  res_r;

  wts_pkg::div_req_t div_req;
  wts_pkg::div_rsp_t div_rsp;

  logic [PW:0]       diff_nxt;
  logic [PW:0]       mag_nxt;
  logic [SW-1:0]     speed_nxt;
  logic              last_nxt;
  logic [TW-1:0]     segf_nxt;
  logic [TW:0]       sum_nxt;

  assign speed_nxt = speed[jcnt_r];
  assign diff_nxt  = {pos_r[jcnt_r][PW-1], pos_r[jcnt_r]}
                   - {prev_r[jcnt_r][PW-1], prev_r[jcnt_r]};
  assign mag_nxt   = diff_nxt[PW] ? (~diff_nxt + 1'b1) : diff_nxt;
  assign last_nxt  = (jcnt_r == JW'(USED - 1));

  // A zero speed limit anywhere forces the full-scale segment.
  always_comb begin
    segf_nxt = sat_r ? wts_pkg::TIME_MAX : seg_r;
    if (segf_nxt < {{(TW - SW){1'b0}}, min_seg}) begin
      segf_nxt = {{(TW - SW){1'b0}}, min_seg};
    end
    sum_nxt = {1'b0, run_r} + {1'b0, segf_nxt};
  end

  assign div_req.start    = (state_r == S_CALC) && (speed_nxt != '0);
  assign div_req.dividend = {mag_nxt[PW-1:0], {wts_pkg::SPEED_FRAC{1'b0}}};
  assign div_req.divisor  = speed_nxt;

  wts_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      jcnt_r  <= '0;
      run_r   <= '0;
      sat_r   <= 1'b0;
      for (int j = 0; j < USED; j++) begin
        prev_r[j] <= '0;
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            for (int j = 0; j < USED; j++) begin
              pos_r[j] <= in_joints[j];
            end
            jcnt_r <= '0;
            seg_r  <= '0;
            sat_r  <= 1'b0;
            if (in_start) begin
              for (int j = 0; j < USED; j++) begin
                prev_r[j] <= in_joints[j];
              end
              run_r   <= '0;
              res_r   <= '0;
              state_r <= S_HOLD;
            end else begin
              state_r <= S_CALC;
            end
          end
        end
        S_CALC: begin
          if (speed_nxt == '0) begin
            sat_r          <= 1'b1;
            prev_r[jcnt_r] <= pos_r[jcnt_r];
            if (last_nxt) begin
              state_r <= S_SUM;
            end else begin
              jcnt_r <= jcnt_r + 1'b1;
            end
          end else begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient > seg_r) begin
              seg_r <= div_rsp.quotient;
            end
            prev_r[jcnt_r] <= pos_r[jcnt_r];
            if (last_nxt) begin
              state_r <= S_SUM;
            end else begin
              jcnt_r  <= jcnt_r + 1'b1;
              state_r <= S_CALC;
            end
          end
        end
        S_SUM: begin
          res_r.segment_time <= segf_nxt;
          if (sum_nxt[TW]) begin
            run_r              <= wts_pkg::TIME_MAX;
            res_r.elapsed_time <= wts_pkg::TIME_MAX;
            res_r.saturated    <= 1'b1;
          end else begin
            run_r              <= sum_nxt[TW-1:0];
            res_r.elapsed_time <= sum_nxt[TW-1:0];
            res_r.saturated    <= sat_r;
          end
          state_r <= S_HOLD;
        end
        S_HOLD: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_HOLD);
  assign res       = res_r;

  // The divider only reports back while the sequencer is waiting for it.
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_WAIT))
    else $error("divider result arrived outside the wait state");

  // An accepted waypoint always leaves the idle state.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted waypoint did not start processing");

endmodule

// ----- rtl/core/waypoint_time_scaler.sv -----
// ----------------------------------------------------------------------------
// waypoint_time_scaler: velocity limited timing of joint waypoints
// Top level with configuration registers, sequencer and result register.
// ----------------------------------------------------------------------------
// Each input word carries one waypoint: in_tuser[0] is the start flag and
// in_tdata holds the joint positions. A start word stores the waypoint and
// answers with all-zero times. Any other word finds, per joint, the position
// change divided by that joint's speed limit, keeps the largest, raises it to
// the minimum segment time and adds it to the running time; the output word
// carries the running time, the segment time and a saturation flag.
// A start word moves from acceptance straight to the result state. Any other
// word is paced by the single serial divider, which produces one quotient
// bit per cycle and is shared by all joints in turn; in_tready is low until
// that word's result has been handed on to the output register.
// The result is held in an output register, so a stalled receiver does not
// stop the next waypoint from being accepted; only the following result waits.
// Reset (synchronous, active low) restores the default speed limits and the
// minimum segment time, clears the stored waypoint and the running time, and
// empties the output register. Configuration words are always accepted and
// should be written while the block is idle.
// ----------------------------------------------------------------------------
module waypoint_time_scaler #(
  parameter int NUM_JOINTS = wts_pkg::NUM_JOINTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input words.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // in_tdata: joint_0 [19:0] .. joint_6 [139:120], zero padding [143:140]
  input  logic [wts_pkg::IN_DATA_W-1:0]     in_tdata,
  // in_tuser: start_req [0]
  input  logic [0:0]                        in_tuser,
  // Result words.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_tdata: elapsed_time [31:0], segment_time [63:32]
  output logic [wts_pkg::OUT_DATA_W-1:0]    out_tdata,
  // out_tuser: saturated [0]
  output logic [0:0]                        out_tuser,
  // Configuration writes.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wts_pkg::SPEED_W-1:0]       cfg_data
);

  localparam int PW = wts_pkg::POS_W;

  wts_pkg::speeds_t             speed_r;
  logic [wts_pkg::SPEED_W-1:0]  min_seg_r;
  wts_pkg::joints_t             joints;
  logic                         res_valid;
  logic                         res_ready;
  wts_pkg::result_t             res;
  logic                         out_valid_r;
  wts_pkg::result_t             out_r;

  // Configuration registers: indexes past the list are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < wts_pkg::FIELD_JOINTS; j++) begin
        speed_r[j] <= wts_pkg::SPEED_RESET;
      end
      min_seg_r <= wts_pkg::MIN_SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index) inside
        [wts_pkg::REG_MAX_SPEED_0:wts_pkg::REG_MAX_SPEED_6]: begin
          speed_r[cfg_index[2:0]] <= cfg_data;
        end
        wts_pkg::REG_MIN_SEG: begin
          min_seg_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Unpack the joint positions from the input word.
  always_comb begin
    for (int j = 0; j < wts_pkg::FIELD_JOINTS; j++) begin
      joints[j] = in_tdata[j*PW +: PW];
    end
  end

  wts_seq #(
    .NUM_JOINTS (NUM_JOINTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_start  (in_tuser[0]),
    .in_joints (joints),
    .speed     (speed_r),
    .min_seg   (min_seg_r),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: refilled whenever it is empty or being emptied.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
      out_r       <= res;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.segment_time, out_r.elapsed_time};
  assign out_tuser  = out_r.saturated;

  // Without saturation the running time includes the segment just added.
  a_time_covers_segment: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.saturated) |-> (out_r.elapsed_time >= out_r.segment_time))
    else $error("running time smaller than its own segment");

  // Saturation with a finite segment can only come from the running time.
  a_sat_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.saturated && (out_r.segment_time != wts_pkg::TIME_MAX))
      |-> (out_r.elapsed_time == wts_pkg::TIME_MAX))
    else $error("saturation flagged without a saturated time");

endmodule

// ----- sim/waypoint_time_scaler_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// waypoint_time_scaler_tb: self-checking regression for the waypoint timer
// Streams joint waypoints into the block, predicts every result word with an
// independent model of the velocity limited timing, and checks each output
// word field by field under random idling on both stream sides.
// ----------------------------------------------------------------------------
module waypoint_time_scaler_tb;

  localparam int FIELD_JOINTS = wts_pkg::FIELD_JOINTS;
  localparam int POS_W        = wts_pkg::POS_W;
  localparam int SPEED_W      = wts_pkg::SPEED_W;
  localparam int SPEED_FRAC   = wts_pkg::SPEED_FRAC;
  localparam int TIME_W       = wts_pkg::TIME_W;
  localparam int IN_DATA_W    = wts_pkg::IN_DATA_W;
  localparam int OUT_DATA_W   = wts_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W    = wts_pkg::CFG_IDX_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_0 = wts_pkg::REG_MAX_SPEED_0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED_6 = wts_pkg::REG_MAX_SPEED_6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG     = wts_pkg::REG_MIN_SEG;

  typedef wts_pkg::joints_t joints_t;
  typedef wts_pkg::result_t result_t;

  // The instance runs with the default joint count; the predictor uses the same.
  localparam int          JOINTS        = wts_pkg::NUM_JOINTS_DEF;
  localparam int          ITEMS         = 1800;
  // Cycles allowed after the last result before a register write is made.
  localparam int unsigned SETTLE_CYCLES = 8;
  // Tail wait, long enough to cover one whole non-start word.
  localparam int unsigned TAIL_CYCLES   = 300;
  localparam int unsigned PRINT_LIMIT   = 40;

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_kind_t;

  // One entry of the driver's schedule: a waypoint word, a register write, or
  // a pause until every outstanding result has been taken.
  typedef struct packed {
    act_kind_t              kind;
    logic                   start;
    joints_t                joints;
    logic [CFG_IDX_W-1:0]   index;
    logic [SPEED_W-1:0]     value;
  } drive_act_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata   = '0;
  logic [0:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic [0:0]             out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [SPEED_W-1:0]     cfg_data   = '0;

  waypoint_time_scaler #(
    .NUM_JOINTS (JOINTS)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the registers, the stored waypoint and
  // the running time, all starting from their reset values.
  // --------------------------------------------------------------------------
  wts_pkg::speeds_t   speed_lim = {FIELD_JOINTS{wts_pkg::SPEED_RESET}};
  logic [SPEED_W-1:0] min_seg   = wts_pkg::MIN_SEG_RESET;
  joints_t            last_pos  = '0;
  logic [TIME_W-1:0]  elapsed   = '0;

  drive_act_t  pending_acts[$];
  result_t     expected_times[$];

  int unsigned err_count       = 0;
  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned sat_seen        = 0;
  int unsigned drains_queued   = 0;
  int unsigned queued_words    = 0;

  // Driver and monitor bookkeeping, each touched by one always block only.
  int unsigned gap_left   = 0;
  int unsigned calm_in    = 0;
  int unsigned settle_cnt = 0;
  int unsigned stall_left = 0;
  int unsigned calm_out   = 0;

  task automatic report_mismatch(input string what, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    if (err_count < PRINT_LIMIT)
      $display("[%0t] mismatch, %s: got %h, expected %h", $time, what, got, want);
    err_count++;
  endtask

  // Works out the result word for one accepted waypoint and updates the
  // predictor's stored waypoint and running time.
  task automatic time_waypoint(input logic start, input joints_t pos);
    result_t                   r;
    logic [TIME_W-1:0]         seg;
    logic                      sat;
    logic signed [POS_W:0]     delta;
    logic [POS_W:0]            mag;
    logic [POS_W+SPEED_FRAC:0] quot;
    logic [TIME_W:0]           total;
    int                        j;
    r = '0;
    if (start) begin
      // A start word only records the waypoint; all times restart at zero.
      for (j = 0; j < JOINTS; j++)
        last_pos[j] = pos[j];
      elapsed = '0;
    end else begin
      seg = '0;
      sat = 1'b0;
      for (j = 0; j < JOINTS; j++) begin
        delta = $signed({pos[j][POS_W-1], pos[j]}) -
                $signed({last_pos[j][POS_W-1], last_pos[j]});
        mag   = delta[POS_W] ? (POS_W+1)'(-delta) : (POS_W+1)'(delta);
        // A joint with no speed limit saturates the segment even if it is still.
        if (speed_lim[j] == '0) begin
          sat = 1'b1;
        end else begin
          quot = {mag, {SPEED_FRAC{1'b0}}} / speed_lim[j];
          if (quot > {1'b0, {TIME_W{1'b1}}})
            quot = {1'b0, {TIME_W{1'b1}}};
          if (quot[TIME_W-1:0] > seg)
            seg = quot[TIME_W-1:0];
        end
      end
      if (sat)
        seg = '1;
      if (seg < TIME_W'(min_seg))
        seg = TIME_W'(min_seg);
      total = {1'b0, elapsed} + {1'b0, seg};
      if (total[TIME_W]) begin
        elapsed = '1;
        sat     = 1'b1;
      end else begin
        elapsed = total[TIME_W-1:0];
      end
      for (j = 0; j < JOINTS; j++)
        last_pos[j] = pos[j];
      r.elapsed_time = elapsed;
      r.segment_time = seg;
      r.saturated    = sat;
    end
    expected_times.insert(expected_times.size(), r);
  endtask

  task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [SPEED_W-1:0] data);
    if (idx >= REG_MAX_SPEED_0 && idx <= REG_MAX_SPEED_6)
      speed_lim[idx[2:0]] = data;
    else if (idx == REG_MIN_SEG)
      min_seg = data;
    // Any higher index is dropped by the block, so nothing changes here.
  endtask

  // Idle lengths: mostly none or a few cycles, now and then longer than a
  // whole non-start computation so that gaps land on every phase of it.
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 24);
    return $urandom_range(40, 300);
  endfunction

  // --------------------------------------------------------------------------
  // Input and configuration driver. Works through the schedule one entry at a
  // time; a word is predicted at the edge where it is accepted, a register
  // write likewise. A drain entry holds everything back until no result is
  // outstanding and the block has had a few cycles to settle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : word_driver
    logic       hold_word;
    logic       hold_cfg;
    logic       next_word_valid;
    logic       next_cfg_valid;
    drive_act_t act;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      cfg_valid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        time_waypoint(in_tuser[0], joints_t'(in_tdata[FIELD_JOINTS*POS_W-1:0]));
        words_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        load_register(cfg_index, cfg_data);
        cfg_writes++;
      end
      hold_word       = in_tvalid && !in_tready;
      hold_cfg        = cfg_valid && !cfg_ready;
      next_word_valid = hold_word;
      next_cfg_valid  = hold_cfg;
      if (!hold_word && !hold_cfg && pending_acts.size() != 0) begin
        act = pending_acts[0];
        case (act.kind)
          ACT_WORD: begin
            if (gap_left != 0) begin
              gap_left--;
            end else begin
              void'(pending_acts.pop_front());
              in_tdata        <= IN_DATA_W'(act.joints);
              in_tuser        <= act.start;
              next_word_valid = 1'b1;
              // Calm stretches send back to back with no idling at all.
              if (calm_in != 0) begin
                calm_in--;
                gap_left = 0;
              end else begin
                gap_left = pick_idle();
                if ($urandom_range(0, 99) < 3)
                  calm_in = $urandom_range(30, 120);
              end
            end
          end
          ACT_CFG: begin
            void'(pending_acts.pop_front());
            cfg_index      <= act.index;
            cfg_data       <= act.value;
            next_cfg_valid = 1'b1;
          end
          default: begin
            if (expected_times.size() != 0) begin
              settle_cnt = 0;
            end else if (settle_cnt >= SETTLE_CYCLES) begin
              void'(pending_acts.pop_front());
              settle_cnt = 0;
            end else begin
              settle_cnt++;
            end
          end
        endcase
      end
      in_tvalid <= next_word_valid;
      cfg_valid <= next_cfg_valid;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor. Each accepted output word is checked against the oldest
  // prediction. The receiver stalls at random, with calm stretches between.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_times.size() == 0) begin
          report_mismatch("result word with nothing expected", out_tdata[TIME_W-1:0], '0);
        end else begin
          want = expected_times.pop_front();
          if (out_tdata[TIME_W-1:0] !== want.elapsed_time)
            report_mismatch("elapsed_time", out_tdata[TIME_W-1:0], want.elapsed_time);
          if (out_tdata[2*TIME_W-1:TIME_W] !== want.segment_time)
            report_mismatch("segment_time", out_tdata[2*TIME_W-1:TIME_W], want.segment_time);
          if (out_tuser[0] !== want.saturated)
            report_mismatch("saturated", TIME_W'(out_tuser[0]), TIME_W'(want.saturated));
          results_checked++;
          if (want.saturated)
            sat_seen++;
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (calm_out != 0) begin
          calm_out--;
        end else if ($urandom_range(0, 99) < 6) begin
          stall_left = pick_idle();
        end else if ($urandom_range(0, 199) == 0) begin
          calm_out = $urandom_range(200, 1500);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Schedule builders.
  // --------------------------------------------------------------------------
  joints_t walk;

  task automatic push_word(input logic start, input joints_t pos);
    drive_act_t a;
    a        = '0;
    a.kind   = ACT_WORD;
    a.start  = start;
    a.joints = pos;
    pending_acts.insert(pending_acts.size(), a);
    queued_words++;
  endtask

  task automatic push_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [SPEED_W-1:0] val);
    drive_act_t a;
    a       = '0;
    a.kind  = ACT_CFG;
    a.index = idx;
    a.value = val;
    pending_acts.insert(pending_acts.size(), a);
  endtask

  // Holding the sender back until every result is in makes the block idle;
  // register writes are for the user to make only then, as the block does not enforce it.
  task automatic push_drain();
    drive_act_t a;
    a      = '0;
    a.kind = ACT_DRAIN;
    pending_acts.insert(pending_acts.size(), a);
    drains_queued++;
  endtask

  task automatic push_all_speeds(input logic [SPEED_W-1:0] val);
    int j;
    for (j = 0; j < FIELD_JOINTS; j++)
      push_cfg(REG_MAX_SPEED_0 + CFG_IDX_W'(j), val);
  endtask

  function automatic joints_t rand_joints();
    joints_t v;
    int      j;
    for (j = 0; j < FIELD_JOINTS; j++)
      v[j] = POS_W'($urandom);
    return v;
  endfunction

  // A fresh setting of every register. Speeds lean towards the extremes and
  // towards values that give segment times of a useful size.
  task automatic random_settings(input logic allow_zero);
    int unsigned        r;
    int                 j;
    int                 zero_joint;
    logic [SPEED_W-1:0] v;
    zero_joint = allow_zero ? int'($urandom_range(0, FIELD_JOINTS - 1)) : -1;
    for (j = 0; j < FIELD_JOINTS; j++) begin
      r = $urandom_range(0, 99);
      if (j == zero_joint)  v = '0;
      else if (r < 10)      v = SPEED_W'(1);
      else if (r < 20)      v = '1;
      else if (r < 35)      v = SPEED_W'($urandom);
      else                  v = SPEED_W'($urandom_range(64, 16384));
      push_cfg(REG_MAX_SPEED_0 + CFG_IDX_W'(j), v);
    end
    r = $urandom_range(0, 99);
    if (r < 15)       v = '0;
    else if (r < 25)  v = '1;
    else              v = SPEED_W'($urandom_range(0, 20000));
    push_cfg(REG_MIN_SEG, v);
    // Writes beyond the last register must leave everything untouched.
    if ($urandom_range(0, 99) < 30)
      push_cfg(REG_MIN_SEG + CFG_IDX_W'($urandom_range(1, 8)), SPEED_W'($urandom));
  endtask

  // One trajectory: a start word, then a random walk from it whose step size
  // is chosen per trajectory, from a few LSBs up to the whole range.
  task automatic run_trajectory();
    int unsigned reach;
    int unsigned steps;
    int unsigned r;
    int          d;
    int          j;
    r = $urandom_range(0, 3);
    case (r)
      0:       reach = 8;
      1:       reach = 700;
      2:       reach = 30000;
      default: reach = 524287;
    endcase
    steps = $urandom_range(2, 24);
    for (j = 0; j < FIELD_JOINTS; j++) begin
      r = $urandom_range(0, 9);
      if (r == 0)       walk[j] = {1'b1, {(POS_W-1){1'b0}}};
      else if (r == 1)  walk[j] = {1'b0, {(POS_W-1){1'b1}}};
      else              walk[j] = POS_W'($urandom);
    end
    push_word(1'b1, walk);
    repeat (steps) begin
      for (j = 0; j < FIELD_JOINTS; j++) begin
        if ($urandom_range(0, 4) != 0) begin
          d       = int'($urandom_range(0, 2 * reach)) - int'(reach);
          walk[j] = walk[j] + POS_W'(d);
        end
      end
      push_word(1'b0, walk);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    joints_t     mixed;
    int unsigned phase;
    int unsigned quota;
    int unsigned r;
    int          j;

    // Directed part, reset settings first. A waypoint before any start word
    // is timed against the all-zero stored waypoint.
    push_word(1'b0, {FIELD_JOINTS{POS_W'(1000)}});
    push_word(1'b1, '0);
    // No motion at all: the minimum segment time wins.
    push_word(1'b0, '0);
    push_word(1'b1, {FIELD_JOINTS{{1'b1, {(POS_W-1){1'b0}}}}});
    // Full-scale swing of every joint.
    push_word(1'b0, {FIELD_JOINTS{{1'b0, {(POS_W-1){1'b1}}}}});
    for (j = 0; j < FIELD_JOINTS; j++)
      mixed[j] = (j % 2 == 0) ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    push_word(1'b0, mixed);
    mixed[FIELD_JOINTS-1] = ~mixed[FIELD_JOINTS-1];
    push_word(1'b0, mixed);

    // Slowest joints and the longest minimum: full swings overflow the
    // running time, which then sticks at its ceiling.
    push_drain();
    push_all_speeds(SPEED_W'(1));
    push_cfg(REG_MIN_SEG, '1);
    push_word(1'b1, {FIELD_JOINTS{{1'b1, {(POS_W-1){1'b0}}}}});
    push_word(1'b0, {FIELD_JOINTS{{1'b0, {(POS_W-1){1'b1}}}}});
    push_word(1'b0, {FIELD_JOINTS{{1'b1, {(POS_W-1){1'b0}}}}});
    push_word(1'b0, {FIELD_JOINTS{{1'b1, {(POS_W-1){1'b0}}}}});
    push_word(1'b1, '0);

    // One joint with a zero speed limit saturates even a motionless segment,
    // while a start word is unaffected. Writes to unused indexes go nowhere.
    push_drain();
    push_all_speeds('1);
    push_cfg(REG_MIN_SEG, '0);
    push_cfg(REG_MAX_SPEED_0 + CFG_IDX_W'(3), '0);
    push_cfg(REG_MIN_SEG + CFG_IDX_W'(1), '0);
    push_cfg('1, SPEED_W'(1));
    push_word(1'b0, '0);
    walk = rand_joints();
    push_word(1'b1, walk);

    // Fastest joints with no minimum: a one-LSB move rounds down to zero time.
    push_drain();
    push_cfg(REG_MAX_SPEED_0 + CFG_IDX_W'(3), '1);
    push_word(1'b0, walk);
    walk[0] = walk[0] + POS_W'(1);
    push_word(1'b0, walk);
    walk[0] = walk[0] + POS_W'(16);
    push_word(1'b0, walk);

    // Random part in phases, each opening with a pause and a new setting of
    // every register; one phase in five has a joint with no speed limit.
    for (phase = 0; queued_words < ITEMS; phase++) begin
      push_drain();
      random_settings(phase % 5 == 3);
      quota = queued_words + 220;
      while (queued_words < quota && queued_words < ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 85)
          run_trajectory();
        else if (r < 95)
          push_word(1'b0, rand_joints());
        else
          push_word(1'b1, rand_joints());
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_acts.size() != 0 || in_tvalid || cfg_valid)
      @(posedge clk);
    while (expected_times.size() != 0)
      @(posedge clk);
    // Let any stray output word show itself before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_times.size() != 0)
      report_mismatch("results still outstanding at the end",
                      TIME_W'(expected_times.size()), '0);

    $display("Run covered %0d waypoint words, %0d checked results (%0d saturated),",
             words_sent, results_checked, sat_seen);
    $display("%0d register writes and %0d idle pauses; %0d mismatches.",
             cfg_writes, drains_queued, err_count);
    if (err_count == 0) begin
      $display("waypoint_time_scaler regression: pass");
    end else begin
      $display("waypoint_time_scaler regression: fail");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run, long stalls included.
  initial begin : watchdog
    #(60_000_000);
    $display("Timed out with %0d results outstanding.", expected_times.size());
    $display("waypoint_time_scaler regression: fail");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wts_pkg.sv
rtl/core/wts_div.sv
rtl/core/wts_seq.sv
rtl/core/waypoint_time_scaler.sv
sim/waypoint_time_scaler_tb.sv
